// ----- hdl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/mme_pkg.sv -----
// ---------------------------------------------------------------------------
// mme_pkg
// Shared types and constants for the matrix multiply engine.
// ---------------------------------------------------------------------------
package mme_pkg;

  localparam int DIM_DEF = 16;   // default matrix dimension
  localparam int IDX_W   = 4;    // row / col field width
  localparam int VAL_W   = 32;   // Q15.16 operand width
  localparam int FRAC_W  = 16;   // fraction bits

  localparam logic [VAL_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [VAL_W-1:0] SAT_NEG = 32'h8000_0000;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_ROW  = 1'b1
  } op_t;

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_t;

  // Tag that rides along with each product term.
  typedef struct packed {
    logic             valid;
    logic             first_term;  // k == 0
    logic             last_term;   // k == DIM-1
    logic             end_row;     // column DIM-1
    logic [IDX_W-1:0] col;
  } mac_ctl_t;

  // Finished dot product status.
  typedef struct packed {
    logic             valid;
    logic             end_row;
    logic [IDX_W-1:0] col;
  } mac_res_t;

endpackage

// ----- hdl/matrix_multiply_engine.sv -----
// ---------------------------------------------------------------------------
// matrix_multiply_engine
// Square Q15.16 matrix product A = B x C with one shared MAC unit.
// ---------------------------------------------------------------------------
//
//  Channel | Dir | tdata (low bit up)                 | tuser / tlast
//  --------+-----+------------------------------------+---------------------
//  in_     | in  | row[3:0] col[7:4] b[39:8] c[71:40] | tuser = op
//  out_    | out | col[3:0] value[35:4] zero[39:36]   | tlast = last of row
//
//  Load transaction: writes B and C at (row, col); no output.
//  Row transaction: DIM*DIM terms (256 at DIM=16), one MAC term per cycle
//  through the single multiplier when not stalled; each result passes the read,
//  product, acc and output registers. in_tready is low while a row is being walked.
//  An output stall freezes the whole read/MAC pipeline and the sequencer.
//  Reset clears control only; the stores are undefined until written.
//
module matrix_multiply_engine #(
  parameter int DIM = mme_pkg::DIM_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // row[3:0], col[7:4], b_value[39:8], c_value[71:40]
  input  logic        in_tuser,   // op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // out_col[3:0], out_value[35:4], zero pad
  output logic        out_tlast   // last
);

  `include "assert_macros.svh"

  localparam int IW     = $clog2(DIM);
  localparam int ADDR_W = $clog2(DIM * DIM);
  localparam int VW     = mme_pkg::VAL_W;

  // input fields
  logic [mme_pkg::IDX_W-1:0] f_row, f_col;
  logic [VW-1:0]             f_b, f_c;
  assign f_row = in_tdata[3:0];
  assign f_col = in_tdata[7:4];
  assign f_b   = in_tdata[39:8];
  assign f_c   = in_tdata[71:40];

  mme_pkg::state_t state_r, state_nxt;
  logic [IW-1:0]   row_r, row_nxt;
  logic [IW-1:0]   j_r, j_nxt;   // result column
  logic [IW-1:0]   k_r, k_nxt;   // term index

  logic accept, in_range, adv, issue;
  logic wr_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr_b, rd_addr_c;
  logic [VW-1:0]     rd_b, rd_c;

  mme_pkg::mac_ctl_t s1_ctl_r, s1_ctl_nxt;
  mme_pkg::mac_res_t res;
  logic [VW-1:0]     res_value;

  logic                      out_valid_r;
  logic [mme_pkg::IDX_W-1:0] out_col_r;
  logic [VW-1:0]             out_value_r;
  logic                      out_last_r;

  // whole pipeline moves when the output slot is free or being drained
  assign adv      = !out_valid_r || out_tready;
  assign accept   = in_tvalid && in_tready;
  assign in_range = (int'(f_row) < DIM) && (int'(f_col) < DIM);
  assign issue    = (state_r == mme_pkg::S_RUN) && adv;

  assign wr_en     = accept && (in_tuser == mme_pkg::OP_LOAD) && in_range;
  assign wr_addr   = ADDR_W'(f_row) * ADDR_W'(DIM) + ADDR_W'(f_col);
  assign rd_addr_b = ADDR_W'(row_r) * ADDR_W'(DIM) + ADDR_W'(k_r);
  assign rd_addr_c = ADDR_W'(k_r) * ADDR_W'(DIM) + ADDR_W'(j_r);

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mme_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r <= row_nxt;
    j_r   <= j_nxt;
    k_r   <= k_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    row_nxt    = row_r;
    j_nxt      = j_r;
    k_nxt      = k_r;
    in_tready  = 1'b0;
    s1_ctl_nxt = '0;
    case (state_r)
      mme_pkg::S_IDLE: begin
        in_tready = 1'b1;
        // row emit; the column field is ignored for range
        if (accept && (in_tuser == mme_pkg::OP_ROW) && (int'(f_row) < DIM)) begin
          row_nxt   = IW'(f_row);
          j_nxt     = '0;
          k_nxt     = '0;
          state_nxt = mme_pkg::S_RUN;
        end
      end
      mme_pkg::S_RUN: begin
        s1_ctl_nxt.valid      = 1'b1;
        s1_ctl_nxt.first_term = (k_r == '0);
        s1_ctl_nxt.last_term  = (k_r == IW'(DIM - 1));
        s1_ctl_nxt.end_row    = (j_r == IW'(DIM - 1));
        s1_ctl_nxt.col        = mme_pkg::IDX_W'(j_r);
        if (adv) begin
          if (k_r == IW'(DIM - 1)) begin
            k_nxt = '0;
            if (j_r == IW'(DIM - 1)) begin
              state_nxt = mme_pkg::S_IDLE;
            end else begin
              j_nxt = j_r + 1'b1;
            end
          end else begin
            k_nxt = k_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = mme_pkg::S_IDLE;
      end
    endcase
  end

  // tag aligned with the registered memory read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
    end else if (adv) begin
      s1_ctl_r <= s1_ctl_nxt;
    end
  end

  mme_store #(
    .DIM    (DIM),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_b      (f_b),
    .wr_c      (f_c),
    .rd_en     (adv),
    .rd_addr_b (rd_addr_b),
    .rd_addr_c (rd_addr_c),
    .rd_b      (rd_b),
    .rd_c      (rd_c)
  );

  mme_mac #(
    .DIM (DIM)
  ) u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .ctl_in    (s1_ctl_r),
    .op_b      ($signed(rd_b)),
    .op_c      ($signed(rd_c)),
    .res       (res),
    .res_value (res_value)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res.valid) begin
      out_col_r   <= res.col;
      out_value_r <= res_value;
      out_last_r  <= res.end_row;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_value_r, out_col_r};
  assign out_tlast  = out_last_r;

  // checks
  `ASSERT_NEXT(a_run_ends, (issue && s1_ctl_nxt.last_term && s1_ctl_nxt.end_row),
               (state_r == mme_pkg::S_IDLE), "row walk did not end after last term")
  `ASSERT_NEXT(a_stall_hold, (!adv), $stable(s1_ctl_r), "read tag moved during stall")
  `ASSERT_SAME(a_last_col, (out_valid_r && out_last_r),
               (out_col_r == mme_pkg::IDX_W'(DIM - 1)), "tlast on wrong column")
  `ASSERT_SAME(a_busy_ready, (s1_ctl_r.valid && !s1_ctl_r.last_term),
               (state_r == mme_pkg::S_RUN), "sequencer left row mid dot product")

endmodule

// ----- hdl/mme_store.sv -----
// ---------------------------------------------------------------------------
// mme_store
// Left and right operand memories: one write port, one registered read each.
// ---------------------------------------------------------------------------
module mme_store #(
  parameter int DIM    = mme_pkg::DIM_DEF,
  parameter int ADDR_W = $clog2(DIM * DIM)
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [ADDR_W-1:0]         wr_addr,
  input  logic [mme_pkg::VAL_W-1:0] wr_b,
  input  logic [mme_pkg::VAL_W-1:0] wr_c,
  input  logic                      rd_en,
  input  logic [ADDR_W-1:0]         rd_addr_b,
  input  logic [ADDR_W-1:0]         rd_addr_c,
  output logic [mme_pkg::VAL_W-1:0] rd_b,
  output logic [mme_pkg::VAL_W-1:0] rd_c
);

  localparam int DEPTH = DIM * DIM;

  logic [mme_pkg::VAL_W-1:0] left_mem  [DEPTH];
  logic [mme_pkg::VAL_W-1:0] right_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      left_mem[wr_addr]  <= wr_b;
      right_mem[wr_addr] <= wr_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_b <= left_mem[rd_addr_b];
      rd_c <= right_mem[rd_addr_c];
    end
  end

endmodule

// ----- hdl/mme_mac.sv -----
// ---------------------------------------------------------------------------
// mme_mac
// Shared multiply-accumulate unit: product stage, exact accumulator, and
// Q15.16 truncation with 32-bit saturation on the finished sum.
// ---------------------------------------------------------------------------
module mme_mac #(
  parameter int DIM = mme_pkg::DIM_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  mme_pkg::mac_ctl_t                ctl_in,
  input  logic signed [mme_pkg::VAL_W-1:0] op_b,
  input  logic signed [mme_pkg::VAL_W-1:0] op_c,
  output mme_pkg::mac_res_t                res,
  output logic [mme_pkg::VAL_W-1:0]        res_value
);

  localparam int PROD_W = 2 * mme_pkg::VAL_W;
  localparam int ACC_W  = PROD_W + $clog2(DIM);

  mme_pkg::mac_ctl_t         ctl2_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic                      done_r;
  logic                      end_row_r;
  logic [mme_pkg::IDX_W-1:0] col_r;
  logic signed [ACC_W-1:0]   shifted;
  logic                      ovf;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl2_r <= '0;
      done_r <= 1'b0;
    end else if (en) begin
      ctl2_r <= ctl_in;
      done_r <= ctl2_r.valid && ctl2_r.last_term;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= op_b * op_c;
      if (ctl2_r.valid) begin
        acc_r     <= ctl2_r.first_term ? ACC_W'(prod_r) : acc_r + ACC_W'(prod_r);
        end_row_r <= ctl2_r.end_row;
        col_r     <= ctl2_r.col;
      end
    end
  end

  // floor shift to Q15.16, then clamp when the upper bits are not a sign run
  assign shifted = acc_r >>> mme_pkg::FRAC_W;
  assign ovf = !((&shifted[ACC_W-1:mme_pkg::VAL_W-1]) ||
                 (~|shifted[ACC_W-1:mme_pkg::VAL_W-1]));

  always_comb begin
    if (ovf) begin
      res_value = shifted[ACC_W-1] ? mme_pkg::SAT_NEG : mme_pkg::SAT_POS;
    end else begin
      res_value = shifted[mme_pkg::VAL_W-1:0];
    end
  end

  assign res.valid   = done_r;
  assign res.end_row = end_row_r;
  assign res.col     = col_r;

endmodule
